// File: rtl/tjc_pkg.sv
// ----------------------------------------------------------------------------
// tjc_pkg: shared types and constants of the tilt joystick conditioner
// Item structs, register indexes, field widths and divider constants.
// ----------------------------------------------------------------------------
package tjc_pkg;

  // default history depth
  localparam int unsigned WindowDefault = 7;

  // field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned TiltW   = 9;
  localparam int unsigned QuotW   = 8;   // |accel| / 166 stays below 256
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  // divide by 166: multiply by 394, shift 16, then one correction step
  localparam int unsigned TiltDivisor = 166;
  localparam int unsigned RecipMul    = 394;
  localparam int unsigned RecipW      = 9;
  localparam int unsigned RecipShift  = 16;

  // register reset values
  localparam logic [1:0]         OrientReset = 2'd0;
  localparam logic [7:0]         DeadReset   = 8'd5;
  localparam logic               InvReset    = 1'b0;
  localparam logic [CfgW-1:0]    ThreshReset = 16'd16000;

  // orientation codes (anything else picks z)
  localparam logic [1:0] OrientX = 2'd0;
  localparam logic [1:0] OrientY = 2'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIENTATION = 2'd0,
    CFG_DEAD_ANGLE  = 2'd1,
    CFG_INVERT      = 2'd2,
    CFG_THRESHOLD   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SampleW-1:0] accel_x;
    logic signed [SampleW-1:0] accel_y;
    logic signed [SampleW-1:0] accel_z;
    logic signed [SampleW-1:0] gyro_x;
    logic signed [SampleW-1:0] gyro_y;
    logic signed [SampleW-1:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic signed [TiltW-1:0] tilt;
    logic [SampleW-1:0]      wobble;
    logic                    attacking;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture selected axis of the incoming item
    logic mul;       // reciprocal multiply
    logic fix;       // quotient correction
    logic dz;        // dead zone and history write
    logic scan;      // one median/max candidate
    logic out_load;  // fill the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage

// File: rtl/tilt_joystick_conditioner_top.sv
// ----------------------------------------------------------------------------
// tilt_joystick_conditioner_top: tilt joystick conditioner
// Median-filtered, dead-zoned tilt and gyro wobble from six-axis samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one six-axis
//   sample per item; an item is taken on a clock edge with valid high and
//   stall low. Every item gives exactly one result item on out_valid_o /
//   out_stall_i / out_data_o (tilt, wobble, attacking).
//   Config registers are written through cfg_we_i / cfg_idx_i / cfg_data_i
//   (0 orientation, 1 dead angle, 2 invert, 3 attack threshold). The user
//   must write them only while no item is in flight; the block does not enforce it.
//   Steps: the accepting edge captures the item, then come a reciprocal
//   multiply, a quotient correction, the dead zone and history write, one
//   rank scan step per held history entry and the output load, after
//   which result valid rises; the scan is shorter while the history is
//   still filling. One item is in work at a time: the input reopens the
//   cycle after the output load, so the next item is not taken before
//   the last one has reached the output register.
//   Reset clears the ring pointer, fill count and the config registers to
//   their defaults; there is no clearing pass. A result waits in the output
//   register while the receiver stalls; the next item is taken meanwhile
//   and the block holds its finished result until the register frees up.
// ----------------------------------------------------------------------------
module tilt_joystick_conditioner_top
  import tjc_pkg::*;
#(
  parameter int unsigned WINDOW = WindowDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  tjc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and history
  tjc_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: rtl/tjc_ctrl.sv
// ----------------------------------------------------------------------------
// tjc_ctrl: sequencer of the tilt joystick conditioner
// Steps one item through divide, dead zone, window scan and output load.
// ----------------------------------------------------------------------------
module tjc_ctrl
  import tjc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_FIX,
    S_DZ,
    S_SCAN,
    S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.mul      = (state_q == S_MUL);
    cmd_o.fix      = (state_q == S_FIX);
    cmd_o.dz       = (state_q == S_DZ);
    cmd_o.scan     = (state_q == S_SCAN);
    cmd_o.out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_MUL;
        end
        S_MUL:  state_q <= S_FIX;
        S_FIX:  state_q <= S_DZ;
        S_DZ:   state_q <= S_SCAN;
        S_SCAN: begin
          if (status_i.scan_last) state_q <= S_OUT;
        end
        S_OUT: begin
          if (cmd_o.out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // an accepted item keeps the input side closed next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after an accepted item");

  // loading the output register raises valid
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_o)
    else $error("output valid missing after load");

  // no load over a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !cmd_o.out_load)
    else $error("output register overwritten while stalled");

endmodule

// File: rtl/tjc_datapath.sv
// ----------------------------------------------------------------------------
// tjc_datapath: arithmetic and history of the tilt joystick conditioner
// Axis select, divide by 166, dead zone, history rings, rank scan for the
// median and running max of the gyro history, config and output registers.
// ----------------------------------------------------------------------------
module tjc_datapath
  import tjc_pkg::*;
#(
  parameter int unsigned WINDOW = WindowDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  in_item_t           in_data_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output out_item_t          out_data_o
);

  localparam int unsigned IdxW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CntW = $clog2(WINDOW + 1);
  localparam int unsigned ProdW = SampleW + RecipW;

  // configuration
  logic [1:0]      orient_q;
  logic [7:0]      dead_q;
  logic            invert_q;
  logic [CfgW-1:0] thresh_q;

  // per-item pipeline registers
  logic                      sign_q;
  logic [SampleW-1:0]        mag_q;
  logic signed [SampleW-1:0] gyr_q;
  logic [QuotW-1:0]          q0_q;
  logic [QuotW-1:0]          quot_q;

  // history rings and control
  logic signed [TiltW-1:0]   twin_q [WINDOW];
  logic signed [SampleW-1:0] gwin_q [WINDOW];
  logic [IdxW-1:0]           slot_q;
  logic [CntW-1:0]           fill_q;
  logic [IdxW-1:0]           idx_q;

  // scan results
  logic signed [TiltW-1:0]   med_q;
  logic signed [SampleW-1:0] gmax_q;
  out_item_t                 out_q;

  // combinational
  logic signed [SampleW-1:0] acc_sel, gyr_sel;
  logic [ProdW-1:0]          prod;
  logic [SampleW:0]          rem;
  logic [QuotW-1:0]          tmag;
  logic [TiltW-1:0]          tilt_new;
  logic signed [TiltW-1:0]   cand;
  logic [WINDOW-1:0]         less_m, le_m;
  logic [CntW-1:0]           less_cnt, le_cnt, k;
  logic [SampleW-1:0]        wob;
  logic [TiltW-1:0]          tilt_out;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= OrientReset;
      dead_q   <= DeadReset;
      invert_q <= InvReset;
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIENTATION: orient_q <= cfg_data_i[1:0];
        CFG_DEAD_ANGLE:  dead_q   <= cfg_data_i[7:0];
        CFG_INVERT:      invert_q <= cfg_data_i[0];
        CFG_THRESHOLD:   thresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // axis select, code 3 falls to z
  always_comb begin
    case (orient_q)
      OrientX: begin
        acc_sel = in_data_i.accel_x;
        gyr_sel = in_data_i.gyro_x;
      end
      OrientY: begin
        acc_sel = in_data_i.accel_y;
        gyr_sel = in_data_i.gyro_y;
      end
      default: begin
        acc_sel = in_data_i.accel_z;
        gyr_sel = in_data_i.gyro_z;
      end
    endcase
  end

  // divider: reciprocal estimate undershoots by at most one
  assign prod = ProdW'(mag_q) * ProdW'(RecipMul);
  assign rem  = {1'b0, mag_q} - (SampleW + 1)'(q0_q * TiltDivisor);

  // dead zone: magnitude at or below the half width drops to zero
  always_comb begin
    tmag     = (quot_q > dead_q) ? (quot_q - dead_q) : '0;
    tilt_new = sign_q ? (TiltW'(0) - TiltW'(tmag)) : TiltW'(tmag);
  end

  // rank of the current candidate among the held entries
  assign cand = twin_q[idx_q];
  assign k    = fill_q >> 1;
  always_comb begin
    for (int j = 0; j < WINDOW; j++) begin
      if (CntW'(j) < fill_q) begin
        less_m[j] = (twin_q[j] < cand);
        le_m[j]   = (twin_q[j] <= cand);
      end else begin
        less_m[j] = 1'b0;
        le_m[j]   = 1'b0;
      end
    end
    less_cnt = CntW'($countones(less_m));
    le_cnt   = CntW'($countones(le_m));
  end

  assign status_o.scan_last = (CntW'(idx_q) == (fill_q - 1'b1));

  // output formatting
  assign tilt_out = invert_q ? (TiltW'(0) - TiltW'(med_q)) : TiltW'(med_q);
  assign wob      = gmax_q[SampleW-1] ? (SampleW'(0) - SampleW'(gmax_q))
                                      : SampleW'(gmax_q);

  // item pipeline and scan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sign_q <= acc_sel[SampleW-1];
      mag_q  <= acc_sel[SampleW-1] ? (SampleW'(0) - SampleW'(acc_sel))
                                   : SampleW'(acc_sel);
      gyr_q  <= gyr_sel;
    end
    if (cmd_i.mul) q0_q <= prod[RecipShift +: QuotW];
    if (cmd_i.fix) begin
      quot_q <= q0_q + QuotW'(rem >= (SampleW + 1)'(TiltDivisor));
    end
    if (cmd_i.dz) begin
      twin_q[slot_q] <= tilt_new;
      gwin_q[slot_q] <= gyr_q;
    end
    if (cmd_i.scan) begin
      if ((less_cnt <= k) && (le_cnt > k)) med_q <= cand;
      if ((idx_q == '0) || (gwin_q[idx_q] > gmax_q)) gmax_q <= gwin_q[idx_q];
    end
    if (cmd_i.out_load) begin
      out_q.tilt      <= tilt_out;
      out_q.wobble    <= wob;
      out_q.attacking <= (wob > thresh_q);
    end
  end

  // ring pointer, fill count, scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.dz) begin
        slot_q <= (slot_q == IdxW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
        if (fill_q != CntW'(WINDOW)) fill_q <= fill_q + 1'b1;
        idx_q <= '0;
      end else if (cmd_i.scan && !status_o.scan_last) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign out_data_o = out_q;

  // a history write always leaves at least one held entry
  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dz |=> fill_q != '0)
    else $error("fill count zero after history write");

  // the scan stays inside the held entries
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> CntW'(idx_q) < fill_q)
    else $error("scan index beyond held entries");

  // fill count grows by one per write until full
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dz && fill_q != CntW'(WINDOW) |=> fill_q == $past(fill_q) + 1'b1)
    else $error("fill count did not advance");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for tilt_joystick_conditioner_top
// Drives six-axis samples through the valid/stall input channel and checks
// every result item against a cycle-free prediction of the tilt median,
// dead zone, direction and gyro wobble. Covers directed corner samples,
// random windows under several register settings, random idling on both
// channels and one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb
  import tjc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // axis codes not named in the package
  localparam logic [1:0] OrientZ     = 2'd2;
  localparam logic [1:0] OrientSpare = 2'd3;

  localparam int HoldOffCycles = 300;
  localparam int QuietLimit    = 2000;
  localparam int SettleCycles  = 16;
  localparam int BlockItems    = 100;
  localparam int RandomBlocks  = 8;

  // --------------------------------------------------------------------------
  // Expected-result store with its own copy of registers and history
  // --------------------------------------------------------------------------
  class tilt_scoreboard;
    logic [1:0]  orient;
    logic [7:0]  dead;
    logic        inv;
    logic [15:0] thresh;
    int          tilt_hist[WindowDefault];
    int          rate_hist[WindowDefault];
    int          slot;
    int          held;
    out_item_t   pending[$];
    int          mismatches;
    int          samples_noted;
    int          results_checked;

    function new();
      orient          = OrientReset;
      dead            = DeadReset;
      inv             = InvReset;
      thresh          = ThreshReset;
      slot            = 0;
      held            = 0;
      mismatches      = 0;
      samples_noted   = 0;
      results_checked = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [15:0] val);
      case (idx)
        CFG_ORIENTATION: orient = val[1:0];
        CFG_DEAD_ANGLE:  dead   = val[7:0];
        CFG_INVERT:      inv    = val[0];
        CFG_THRESHOLD:   thresh = val;
        default: ;
      endcase
    endfunction

    // work out the result an accepted sample must produce
    function void note_sample(in_item_t s);
      int        accel;
      int        rate;
      int        tilt;
      int        dz;
      int        mag;
      int        key;
      int        j;
      int        peak;
      int        rank_buf[WindowDefault];
      out_item_t want;
      case (orient)
        OrientX: begin
          accel = int'($signed(s.accel_x));
          rate  = int'($signed(s.gyro_x));
        end
        OrientY: begin
          accel = int'($signed(s.accel_y));
          rate  = int'($signed(s.gyro_y));
        end
        default: begin
          accel = int'($signed(s.accel_z));
          rate  = int'($signed(s.gyro_z));
        end
      endcase

      // scale and dead zone
      dz   = int'(dead);
      tilt = accel / int'(TiltDivisor);
      mag  = (tilt < 0) ? -tilt : tilt;
      if (mag < dz) tilt = 0;
      else if (tilt > 0) tilt = tilt - dz;
      else if (tilt < 0) tilt = tilt + dz;

      // history ring
      tilt_hist[slot] = tilt;
      rate_hist[slot] = rate;
      slot = (slot + 1) % WindowDefault;
      if (held < WindowDefault) held++;

      // median: rank held/2 of the held tilts
      for (int i = 0; i < held; i++) rank_buf[i] = tilt_hist[i];
      for (int i = 1; i < held; i++) begin
        key = rank_buf[i];
        j   = i;
        while (j > 0 && rank_buf[j-1] > key) begin
          rank_buf[j] = rank_buf[j-1];
          j--;
        end
        rank_buf[j] = key;
      end
      tilt = rank_buf[held/2];
      if (inv) tilt = -tilt;

      // wobble from the largest held gyro value
      peak = rate_hist[0];
      for (int i = 1; i < held; i++) if (rate_hist[i] > peak) peak = rate_hist[i];
      mag = (peak < 0) ? -peak : peak;

      want.tilt      = 9'(tilt);
      want.wobble    = 16'(mag);
      want.attacking = (mag > int'(thresh));
      pending.push_back(want);
      samples_noted++;
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_checked++;
      if (pending.size() == 0) begin
        note_failure($sformatf("result with nothing expected: tilt %0d wobble %0d att %0b",
                               got.tilt, got.wobble, got.attacking));
        return;
      end
      want = pending.pop_front();
      if (got.tilt !== want.tilt || got.wobble !== want.wobble ||
          got.attacking !== want.attacking)
        note_failure($sformatf({"result %0d: tilt exp %0d got %0d, ",
                                "wobble exp %0d got %0d, att exp %0b got %0b"},
                               results_checked, want.tilt, got.tilt,
                               want.wobble, got.wobble,
                               want.attacking, got.attacking));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its ports
  // --------------------------------------------------------------------------
  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  in_item_t          in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  out_item_t         out_data_o;
  logic              cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]   cfg_data_i;

  tilt_joystick_conditioner_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  tilt_scoreboard sb;
  in_item_t       stim_q[$];
  int             send_idle_pct;
  int             recv_stall_pct;
  bit             hold_off_req;
  int             settings_applied;
  int             quiet_cycles;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Monitor and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_sample(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Timeout: no item moved for %0d cycles", QuietLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_off_req) begin
        hold_left    = HoldOffCycles;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_item_t sample_of(int ax, int ay, int az, int gx, int gy, int gz);
    in_item_t s;
    s.accel_x = 16'(ax);
    s.accel_y = 16'(ay);
    s.accel_z = 16'(az);
    s.gyro_x  = 16'(gx);
    s.gyro_y  = 16'(gy);
    s.gyro_z  = 16'(gz);
    return s;
  endfunction

  // accel: full range, near zero, around multiples of the divisor, extremes
  function automatic int rand_accel();
    case ($urandom_range(3))
      0: return int'($signed(16'($urandom)));
      1: return int'($urandom_range(5000)) - 2500;
      2: return (int'($urandom_range(394)) - 197) * int'(TiltDivisor)
                + int'($urandom_range(2)) - 1;
      default: begin
        case ($urandom_range(3))
          0: return -32768;
          1: return 32767;
          2: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // gyro: biased negative so whole windows of negative rates occur
  function automatic int rand_gyro();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return ($urandom_range(1) != 0) ? 32767 : -32768;
    if (pick < 6) return -int'($urandom_range(1, 32768));
    return int'($signed(16'($urandom)));
  endfunction

  // send every queued sample, leaving valid high between back-to-back items
  task automatic send_queue();
    in_item_t s;
    while (stim_q.size() != 0) begin
      s = stim_q.pop_front();
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= s;
      do @(posedge clk_i); while (in_stall_o);
    end
    in_valid_i <= 1'b0;
  endtask

  // wait until every expected result is back, then let the block settle
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write all four registers, one per cycle
  task automatic apply_settings(logic [1:0] orient, logic [7:0] dead, logic inv,
                                logic [15:0] thresh);
    logic [15:0] vals[cfg_idx_e];
    cfg_idx_e    idx;
    vals[CFG_ORIENTATION] = 16'(orient);
    vals[CFG_DEAD_ANGLE]  = 16'(dead);
    vals[CFG_INVERT]      = 16'(inv);
    vals[CFG_THRESHOLD]   = thresh;
    idx = idx.first();
    do begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= vals[idx];
      sb.set_register(idx, vals[idx]);
      @(posedge clk_i);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int errors;
    sb               = new();
    in_valid_i       = 1'b0;
    in_data_i        = '0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_ORIENTATION;
    cfg_data_i       = '0;
    rst_ni           = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_off_req     = 1'b0;
    settings_applied = 0;
    quiet_cycles     = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: x axis, dead zone 5, threshold 16000
    stim_q.push_back(sample_of(-32768, -32768, -32768, -32768, -32768, -32768));
    stim_q.push_back(sample_of(32767, 100, -100, 32767, 5, -5));
    stim_q.push_back(sample_of(0, 32767, -32768, 0, 1, -1));
    stim_q.push_back(sample_of(830, 7, 9, 16000, 2, 3));     // on the dead-zone edge
    stim_q.push_back(sample_of(-830, -7, -9, -16000, 2, 3));
    stim_q.push_back(sample_of(996, 0, 0, 100, 0, 0));       // just past the edge
    stim_q.push_back(sample_of(-996, 0, 0, -100, 0, 0));
    stim_q.push_back(sample_of(165, 0, 0, 15999, 0, 0));     // truncates to zero
    stim_q.push_back(sample_of(-165, 0, 0, 16001, 0, 0));
    stim_q.push_back(sample_of(166, 0, 0, 5, 0, 0));
    send_queue();
    drain();

    // y axis, no dead zone, inverted, threshold equal to the window peak
    apply_settings(OrientY, 8'd0, 1'b1, 16'd32767);
    stim_q.push_back(sample_of(0, 32767, 0, 0, 32767, 0));
    stim_q.push_back(sample_of(0, -32768, 0, 0, -1, 0));
    stim_q.push_back(sample_of(0, 166, 0, 0, 3, 0));
    stim_q.push_back(sample_of(0, -166, 0, 0, -3, 0));
    send_queue();
    drain();

    // z axis, dead zone at the largest tilt magnitude, zero threshold
    apply_settings(OrientZ, 8'd197, 1'b0, 16'd0);
    stim_q.push_back(sample_of(0, 0, 32767, 0, 0, 0));
    stim_q.push_back(sample_of(0, 0, -32768, 0, 0, -5));
    stim_q.push_back(sample_of(0, 0, 0, 0, 0, 7));
    send_queue();
    drain();

    // spare orientation code, dead zone beyond any tilt, threshold at full scale
    apply_settings(OrientSpare, 8'd255, 1'b1, 16'd32768);
    stim_q.push_back(sample_of(0, 0, 32767, 0, 0, -32768));
    stim_q.push_back(sample_of(0, 0, -32767, 0, 0, -32768));
    send_queue();
    drain();

    // random windows under a series of settings and idling patterns
    for (int blk = 0; blk < RandomBlocks; blk++) begin
      case (blk)
        0: apply_settings(OrientX, 8'd0, 1'b0, 16'd0);
        1: apply_settings(OrientY, 8'd197, 1'b1, 16'd32768);
        2: apply_settings(OrientZ, 8'd255, 1'b0, 16'hFFFF);
        default:
          apply_settings(2'($urandom_range(3)),
                         ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(12)),
                         1'($urandom_range(1)),
                         ($urandom_range(1) != 0) ? 16'($urandom_range(32768))
                                                  : 16'($urandom));
      endcase
      if (blk < 3) begin
        send_idle_pct  = 10;
        recv_stall_pct = 47;
      end else if (blk < 6) begin
        send_idle_pct  = 47;
        recv_stall_pct = 10;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      // long receiver hold-off while the sender keeps offering
      if (blk == 6) hold_off_req = 1'b1;
      repeat (BlockItems)
        stim_q.push_back(sample_of(rand_accel(), rand_accel(), rand_accel(),
                                   rand_gyro(), rand_gyro(), rand_gyro()));
      send_queue();
      drain();
    end

    errors = sb.mismatches + sb.pending.size();
    $display("Covered %0d samples and %0d results over %0d register settings,",
             sb.samples_noted, sb.results_checked, settings_applied);
    $display("all axis codes, dead-zone edges, window fill and a %0d-cycle output hold-off.",
             HoldOffCycles);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tjc_pkg.sv
rtl/tjc_ctrl.sv
rtl/tjc_datapath.sv
rtl/tilt_joystick_conditioner_top.sv
tb/tb.sv
